/* design/gyro_heading_turn_controller_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the gyro heading turn controller
// Checks run on clk and are held off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef GYRO_HEADING_TURN_CONTROLLER_ASSERT_SVH
`define GYRO_HEADING_TURN_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define GHTC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define GHTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/ghtc_pkg.sv */
// ----------------------------------------------------------------------------
// ghtc_pkg
// Types, codes and helper functions shared by the turn controller modules.
// ----------------------------------------------------------------------------
package ghtc_pkg;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 13;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_QUARTER_TIMEOUT = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_HALF_TIMEOUT    = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_TOLERANCE       = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_QUARTER_SLOW    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_HALF_SLOW       = 3'd4;

	localparam logic [1:0] FUNC_START  = 2'd0;
	localparam logic [1:0] FUNC_SAMPLE = 2'd1;
	localparam logic [1:0] FUNC_TICK   = 2'd2;
	localparam logic [1:0] FUNC_NOP    = 2'd3;

	localparam logic [1:0] MODE_LEFT  = 2'd0;
	localparam logic [1:0] MODE_RIGHT = 2'd1;
	localparam logic [1:0] MODE_HALF  = 2'd2;
	localparam logic [1:0] MODE_BAD   = 2'd3;

	localparam logic [1:0] FIN_NONE    = 2'd0;
	localparam logic [1:0] FIN_REACHED = 2'd1;
	localparam logic [1:0] FIN_TIMEOUT = 2'd2;

	localparam logic [12:0] ELAPSED_MAX = 13'h1FFF;

	typedef struct packed {
		logic [12:0] quarter_timeout_ms;
		logic [12:0] half_timeout_ms;
		logic [3:0]  tolerance_deg;
		logic [7:0]  quarter_slow_deg;
		logic [8:0]  half_slow_deg;
	} cfg_t;

	typedef struct packed {
		logic [1:0] func;
		logic [1:0] turn_mode;
		logic [7:0] drive_speed;
		logic [8:0] heading_deg;
	} item_t;

	typedef struct packed {
		logic [1:0] finish_code;
		logic       turning;
		logic [7:0] pwm_duty;
		logic       left_back_dir;
		logic       left_front_dir;
		logic       right_back_dir;
		logic       right_front_dir;
	} result_t;

	// Exact floor(x / 5) for 8-bit x: (x * 205) >> 10.
	function automatic logic [7:0] div5(input logic [7:0] x);
		logic [15:0] prod;
		prod = {8'd0, x} * 16'd205;
		return {2'b00, prod[15:10]};
	endfunction

	// Snap a wrapped heading to the nearest cardinal target.
	function automatic logic [8:0] snap_target(input logic [9:0] a);
		logic [8:0] t;
		if (a >= 10'd45 && a < 10'd135) begin
			t = 9'd90;
		end else if (a >= 10'd135 && a < 10'd225) begin
			t = 9'd180;
		end else if (a >= 10'd225 && a < 10'd315) begin
			t = 9'd270;
		end else begin
			t = 9'd360;
		end
		return t;
	endfunction

endpackage

/* design/gyro_heading_turn_controller.sv */
// ----------------------------------------------------------------------------
// gyro_heading_turn_controller
// Gyro-guided quarter and half turn controller for a four-motor robot.
//
//   Channel   Direction  Handshake          Contents
//   s_*       in         tvalid/tready      start, heading sample or ms tick
//   m_*       out        tvalid/tready      motor directions, duty, status
//   cfg_*     in         cfg_we             timeouts, tolerance, slow angles
//
// A request is registered, evaluated against the turn state combinationally and
// written to the result register.
// One request is taken every cycle while the result register drains.
// The sink stalling holds the result register and then the input register.
// Reset clears the turn state and loads the default configuration.
// ----------------------------------------------------------------------------
module gyro_heading_turn_controller (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// turn_mode[1:0], drive_speed[9:2], heading_deg[18:10], zero fill
	input  logic [ghtc_pkg::IN_DATA_W-1:0]     s_tdata,
	// func[1:0]
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// right_front_dir[0], right_back_dir[1], left_front_dir[2], left_back_dir[3],
	// pwm_duty[11:4], turning[12], finish_code[14:13], zero fill
	output logic [ghtc_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                               cfg_we,
	input  logic [ghtc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [ghtc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
	import ghtc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	logic    out_ready;
	logic    advance;
	result_t result;
	result_t out_result;

	assign advance  = valid_s1 && out_ready;
	assign s_tready = !valid_s1 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.func        <= s_tuser;
			item_s1.turn_mode   <= s_tdata[1:0];
			item_s1.drive_speed <= s_tdata[9:2];
			item_s1.heading_deg <= s_tdata[18:10];
		end
	end

	ghtc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ghtc_turn_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.result  (result)
	);

	ghtc_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (valid_s1),
		.in_result  (result),
		.in_ready   (out_ready),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (out_result)
	);

	assign m_tdata = {1'b0, out_result};

`include "gyro_heading_turn_controller_assert.svh"

	`GHTC_ASSERT_NOW(a_finish_stops, m_tvalid && out_result.finish_code != FIN_NONE, !out_result.turning, "finished result still turning")
	`GHTC_ASSERT_NOW(a_idle_quiet, m_tvalid && !out_result.turning, out_result.pwm_duty == 8'd0 && out_result.right_front_dir == 1'b0 && out_result.left_front_dir == 1'b0, "idle result drives motors")
	`GHTC_ASSERT_NOW(a_dir_pair, m_tvalid && out_result.turning, out_result.right_front_dir != out_result.right_back_dir && out_result.left_front_dir != out_result.left_back_dir, "inconsistent motor directions")
	`GHTC_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, valid_s1, "accepted request lost")

endmodule

/* design/ghtc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// ghtc_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module ghtc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [ghtc_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [ghtc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output ghtc_pkg::cfg_t               cfg
);
	import ghtc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.quarter_timeout_ms <= 13'd3000;
			cfg_q.half_timeout_ms    <= 13'd6000;
			cfg_q.tolerance_deg      <= 4'd1;
			cfg_q.quarter_slow_deg   <= 8'd70;
			cfg_q.half_slow_deg      <= 9'd160;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_QUARTER_TIMEOUT: cfg_q.quarter_timeout_ms <= cfg_wdata;
				REG_HALF_TIMEOUT:    cfg_q.half_timeout_ms    <= cfg_wdata;
				REG_TOLERANCE:       cfg_q.tolerance_deg      <= cfg_wdata[3:0];
				REG_QUARTER_SLOW:    cfg_q.quarter_slow_deg   <= cfg_wdata[7:0];
				REG_HALF_SLOW:       cfg_q.half_slow_deg      <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* design/ghtc_turn_core.sv */
// ----------------------------------------------------------------------------
// ghtc_turn_core
// Turn state and the per-request update that yields the next drive result.
// ----------------------------------------------------------------------------
module ghtc_turn_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  ghtc_pkg::item_t  item,
	input  ghtc_pkg::cfg_t   cfg,
	output ghtc_pkg::result_t result
);
	import ghtc_pkg::*;

	logic        active_q;
	logic [1:0]  mode_held_q;
	logic [8:0]  start_heading_q;
	logic [8:0]  target_heading_q;
	logic [7:0]  base_speed_q;
	logic [12:0] elapsed_ms_q;
	logic        slowed_q;

	logic        active_d;
	logic [1:0]  mode_held_d;
	logic [8:0]  start_heading_d;
	logic [8:0]  target_heading_d;
	logic [7:0]  base_speed_d;
	logic [12:0] elapsed_ms_d;
	logic        slowed_d;
	logic [1:0]  fin;

	logic [9:0]  h10;
	logic [9:0]  wrapped;
	logic [9:0]  tol_lo;
	logic [9:0]  tol_hi;
	logic        in_tol;
	logic signed [10:0] turned_left;
	logic signed [10:0] turned_right;
	logic        slow_hit;
	logic [12:0] elapsed_inc;
	logic [12:0] limit;

	always_comb begin
		h10 = {1'b0, item.heading_deg};
		case (item.turn_mode)
			MODE_LEFT: wrapped = (h10 < 10'd90) ? h10 + 10'd270 : h10 - 10'd90;
			MODE_RIGHT: wrapped = (h10 + 10'd90 >= 10'd360) ? h10 - 10'd270 : h10 + 10'd90;
			default: wrapped = (h10 + 10'd180 >= 10'd360) ? h10 - 10'd180 : h10 + 10'd180;
		endcase

		tol_lo = {1'b0, target_heading_q} - {6'd0, cfg.tolerance_deg};
		tol_hi = {1'b0, target_heading_q} + {6'd0, cfg.tolerance_deg};
		in_tol = (h10 >= tol_lo) && (h10 <= tol_hi);

		turned_left  = $signed({2'b00, start_heading_q}) - $signed({2'b00, item.heading_deg});
		turned_right = $signed({2'b00, item.heading_deg}) - $signed({2'b00, start_heading_q});
		case (mode_held_q)
			MODE_LEFT:  slow_hit = turned_left >= $signed({3'b000, cfg.quarter_slow_deg});
			MODE_RIGHT: slow_hit = turned_right >= $signed({3'b000, cfg.quarter_slow_deg});
			default:    slow_hit = turned_right >= $signed({2'b00, cfg.half_slow_deg});
		endcase

		elapsed_inc = (elapsed_ms_q < ELAPSED_MAX) ? elapsed_ms_q + 13'd1 : elapsed_ms_q;
		limit = (mode_held_q == MODE_HALF) ? cfg.half_timeout_ms : cfg.quarter_timeout_ms;

		active_d         = active_q;
		mode_held_d      = mode_held_q;
		start_heading_d  = start_heading_q;
		target_heading_d = target_heading_q;
		base_speed_d     = base_speed_q;
		elapsed_ms_d     = elapsed_ms_q;
		slowed_d         = slowed_q;
		fin              = FIN_NONE;

		unique case (item.func)
			FUNC_START: begin
				if (item.turn_mode != MODE_BAD) begin
					active_d         = 1'b1;
					mode_held_d      = item.turn_mode;
					start_heading_d  = item.heading_deg;
					target_heading_d = snap_target(wrapped);
					base_speed_d     = item.drive_speed;
					elapsed_ms_d     = '0;
					slowed_d         = 1'b0;
				end
			end
			FUNC_SAMPLE: begin
				if (active_q) begin
					if (in_tol) begin
						active_d = 1'b0;
						fin      = FIN_REACHED;
					end else if (slow_hit) begin
						slowed_d = 1'b1;
					end
				end
			end
			FUNC_TICK: begin
				if (active_q) begin
					elapsed_ms_d = elapsed_inc;
					if (elapsed_inc >= limit) begin
						active_d = 1'b0;
						fin      = FIN_TIMEOUT;
					end
				end
			end
			default: ;
		endcase

		result = '0;
		result.finish_code = fin;
		if (active_d) begin
			if (mode_held_d == MODE_LEFT) begin
				result.right_front_dir = 1'b1;
				result.left_back_dir   = 1'b1;
			end else begin
				result.right_back_dir  = 1'b1;
				result.left_front_dir  = 1'b1;
			end
			result.pwm_duty = slowed_d ? div5(base_speed_d) : base_speed_d;
			result.turning  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q         <= 1'b0;
			mode_held_q      <= MODE_LEFT;
			start_heading_q  <= '0;
			target_heading_q <= '0;
			base_speed_q     <= '0;
			elapsed_ms_q     <= '0;
			slowed_q         <= 1'b0;
		end else if (advance) begin
			active_q         <= active_d;
			mode_held_q      <= mode_held_d;
			start_heading_q  <= start_heading_d;
			target_heading_q <= target_heading_d;
			base_speed_q     <= base_speed_d;
			elapsed_ms_q     <= elapsed_ms_d;
			slowed_q         <= slowed_d;
		end
	end

endmodule

/* design/ghtc_out_stage.sv */
// ----------------------------------------------------------------------------
// ghtc_out_stage
// Result register that holds a finished result until the sink takes it.
// ----------------------------------------------------------------------------
module ghtc_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  ghtc_pkg::result_t in_result,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output ghtc_pkg::result_t out_result
);
	import ghtc_pkg::*;

	logic    valid_q;
	result_t result_q;

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			result_q <= in_result;
		end
	end

	assign out_valid  = valid_q;
	assign out_result = result_q;

endmodule

/* dv/gyro_heading_turn_controller_tb.sv */
// ----------------------------------------------------------------------------
// gyro_heading_turn_controller_tb
// Self-checking testbench for the gyro heading turn controller. A queue of
// start, heading sample and millisecond tick requests feeds the input stream,
// and a shadow model of the turn state predicts each status result. A
// directed opening covers the reset settings, the heading wrap and the
// cardinal snap, the target of 360, a zero timeout and the illegal codes.
// Random turn sequences then run under several register settings, with random
// gaps on both streams in all but one of them.
// ----------------------------------------------------------------------------
module gyro_heading_turn_controller_tb;
	import ghtc_pkg::*;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	item_t   turn_requests[$];
	result_t expected_status[$];
	int      gap_pct = 28;
	int      queued = 0;
	int      accepted = 0;
	int      checked = 0;
	int      reached_cnt = 0;
	int      timeout_cnt = 0;
	int      errors = 0;

	// Shadow copy of the registers and the turn state.
	cfg_t        cfg_shadow = '{13'd3000, 13'd6000, 4'd1, 8'd70, 9'd160};
	logic        turn_on = 1'b0;
	logic [1:0]  held_mode = MODE_LEFT;
	logic [8:0]  start_hdg = '0;
	logic [8:0]  target_hdg = '0;
	logic [7:0]  base_duty = '0;
	logic [12:0] elapsed = '0;
	logic        slowed = 1'b0;

	gyro_heading_turn_controller u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [8:0] cardinal_target(logic [1:0] mode, logic [8:0] hdg);
		int a;
		if (mode == MODE_LEFT) begin
			a = int'(hdg) - 90;
			if (a < 0) a += 360;
		end else begin
			a = int'(hdg) + ((mode == MODE_RIGHT) ? 90 : 180);
			if (a >= 360) a -= 360;
		end
		if (a >= 45 && a < 135) return 9'd90;
		if (a >= 135 && a < 225) return 9'd180;
		if (a >= 225 && a < 315) return 9'd270;
		return 9'd360;
	endfunction

	function automatic result_t predict_turn(item_t req);
		result_t r;
		int hdg, tgt, tol, s, lim;
		r = '0;
		r.finish_code = FIN_NONE;
		hdg = req.heading_deg;
		tgt = target_hdg;
		tol = cfg_shadow.tolerance_deg;
		s = start_hdg;
		case (req.func)
			FUNC_START: begin
				if (req.turn_mode != MODE_BAD) begin
					turn_on = 1'b1;
					held_mode = req.turn_mode;
					start_hdg = req.heading_deg;
					target_hdg = cardinal_target(req.turn_mode, req.heading_deg);
					base_duty = req.drive_speed;
					elapsed = '0;
					slowed = 1'b0;
				end
			end
			FUNC_SAMPLE: begin
				if (turn_on) begin
					if (hdg >= tgt - tol && hdg <= tgt + tol) begin
						turn_on = 1'b0;
						r.finish_code = FIN_REACHED;
					end else if (held_mode == MODE_LEFT) begin
						if (s - hdg >= int'(cfg_shadow.quarter_slow_deg)) slowed = 1'b1;
					end else if (held_mode == MODE_RIGHT) begin
						if (hdg - s >= int'(cfg_shadow.quarter_slow_deg)) slowed = 1'b1;
					end else begin
						if (hdg - s >= int'(cfg_shadow.half_slow_deg)) slowed = 1'b1;
					end
				end
			end
			FUNC_TICK: begin
				if (turn_on) begin
					lim = (held_mode == MODE_HALF) ? cfg_shadow.half_timeout_ms :
						cfg_shadow.quarter_timeout_ms;
					if (elapsed != ELAPSED_MAX) elapsed = elapsed + 13'd1;
					if (int'(elapsed) >= lim) begin
						turn_on = 1'b0;
						r.finish_code = FIN_TIMEOUT;
					end
				end
			end
			default: ;
		endcase
		if (turn_on) begin
			if (held_mode == MODE_LEFT) begin
				r.right_front_dir = 1'b1;
				r.left_back_dir = 1'b1;
			end else begin
				r.right_back_dir = 1'b1;
				r.left_front_dir = 1'b1;
			end
			r.pwm_duty = slowed ? base_duty / 8'd5 : base_duty;
			r.turning = 1'b1;
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, int got, int want);
		$display("MISMATCH result %0d: %s got %0d expected %0d", checked, field, got,
			want);
		errors++;
	endtask

	task automatic queue_item(logic [1:0] func, logic [1:0] mode, logic [7:0] speed,
			int hdg);
		item_t req;
		req.func = func;
		req.turn_mode = mode;
		req.drive_speed = speed;
		req.heading_deg = hdg[8:0];
		turn_requests.push_back(req);
		queued++;
	endtask

	// One turn: a start followed by samples drifting toward the target,
	// samples near the target and millisecond ticks. Now and then a stray
	// request with any code and any heading is queued instead.
	task automatic queue_turn_sequence();
		logic [1:0] mode;
		int hdg, cur, tgt, len, pick, step;
		if ($urandom_range(99) < 12) begin
			queue_item(2'($urandom_range(3)), 2'($urandom_range(3)), 8'($urandom),
				$urandom_range(511));
			return;
		end
		mode = 2'($urandom_range(2));
		hdg = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(359);
		queue_item(FUNC_START, mode, 8'($urandom), hdg);
		tgt = cardinal_target(mode, 9'(hdg));
		cur = hdg;
		len = $urandom_range(14, 3);
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(99);
			if (pick < 30) begin
				queue_item(FUNC_TICK, 2'($urandom), 8'($urandom), $urandom_range(511));
			end else if (pick < 55) begin
				cur = tgt + $urandom_range(24) - 12;
				if (cur < 0) cur = 0;
				queue_item(FUNC_SAMPLE, 2'($urandom), 8'($urandom), cur);
			end else begin
				step = $urandom_range(60, 5);
				if (mode == MODE_LEFT) begin
					cur -= step;
					if (cur < 0) cur += 360;
				end else begin
					cur += step;
					if (cur > 370) cur -= 360;
				end
				queue_item(FUNC_SAMPLE, 2'($urandom), 8'($urandom), cur);
			end
		end
	endtask

	task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, int value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= value[CFG_DATA_W-1:0];
		case (addr)
			REG_QUARTER_TIMEOUT: cfg_shadow.quarter_timeout_ms = value[12:0];
			REG_HALF_TIMEOUT:    cfg_shadow.half_timeout_ms = value[12:0];
			REG_TOLERANCE:       cfg_shadow.tolerance_deg = value[3:0];
			REG_QUARTER_SLOW:    cfg_shadow.quarter_slow_deg = value[7:0];
			REG_HALF_SLOW:       cfg_shadow.half_slow_deg = value[8:0];
			default: ;
		endcase
	endtask

	task automatic write_setting(int qt, int ht, int tol, int qs, int hs);
		write_reg(REG_QUARTER_TIMEOUT, qt);
		write_reg(REG_HALF_TIMEOUT, ht);
		write_reg(REG_TOLERANCE, tol);
		write_reg(REG_QUARTER_SLOW, qs);
		write_reg(REG_HALF_SLOW, hs);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_idle(int settle);
		while (turn_requests.size() != 0 || s_tvalid || expected_status.size() != 0)
			@(negedge clk);
		repeat (settle) @(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		item_t req;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (turn_requests.size() != 0 && $urandom_range(99) >= gap_pct) begin
				req = turn_requests.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= {5'd0, req.heading_deg, req.drive_speed, req.turn_mode};
				s_tuser <= req.func;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= gap_pct);
		end
	end

	always @(posedge clk) begin
		result_t got, want;
		item_t req;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = m_tdata[14:0];
				if (expected_status.size() == 0) begin
					report_mismatch("unexpected result, value", int'(got), 0);
				end else begin
					want = expected_status.pop_front();
					if (got.right_front_dir !== want.right_front_dir)
						report_mismatch("right_front_dir", got.right_front_dir,
							want.right_front_dir);
					if (got.right_back_dir !== want.right_back_dir)
						report_mismatch("right_back_dir", got.right_back_dir,
							want.right_back_dir);
					if (got.left_front_dir !== want.left_front_dir)
						report_mismatch("left_front_dir", got.left_front_dir,
							want.left_front_dir);
					if (got.left_back_dir !== want.left_back_dir)
						report_mismatch("left_back_dir", got.left_back_dir,
							want.left_back_dir);
					if (got.pwm_duty !== want.pwm_duty)
						report_mismatch("pwm_duty", got.pwm_duty, want.pwm_duty);
					if (got.turning !== want.turning)
						report_mismatch("turning", got.turning, want.turning);
					if (got.finish_code !== want.finish_code)
						report_mismatch("finish_code", got.finish_code, want.finish_code);
					checked++;
				end
			end
			if (s_tvalid && s_tready) begin
				req.func = s_tuser;
				req.turn_mode = s_tdata[1:0];
				req.drive_speed = s_tdata[9:2];
				req.heading_deg = s_tdata[18:10];
				want = predict_turn(req);
				if (want.finish_code == FIN_REACHED) reached_cnt++;
				if (want.finish_code == FIN_TIMEOUT) timeout_cnt++;
				expected_status.push_back(want);
				accepted++;
			end
		end
	end

	initial begin
		int mark;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: idle requests, the heading wrap and the snap to 360.
		queue_item(FUNC_SAMPLE, MODE_LEFT, 8'd0, 0);
		queue_item(FUNC_TICK, MODE_HALF, 8'd255, 511);
		queue_item(FUNC_NOP, MODE_BAD, 8'd0, 0);
		queue_item(FUNC_START, MODE_LEFT, 8'd255, 359);
		queue_item(FUNC_SAMPLE, MODE_LEFT, 8'd0, 280);
		queue_item(FUNC_SAMPLE, MODE_LEFT, 8'd0, 271);
		queue_item(FUNC_START, MODE_RIGHT, 8'd0, 511);
		queue_item(FUNC_START, MODE_BAD, 8'd77, 100);
		queue_item(FUNC_NOP, MODE_LEFT, 8'd0, 0);
		queue_item(FUNC_SAMPLE, MODE_LEFT, 8'd0, 269);
		queue_item(FUNC_START, MODE_HALF, 8'd200, 180);
		queue_item(FUNC_SAMPLE, MODE_LEFT, 8'd0, 340);
		queue_item(FUNC_SAMPLE, MODE_LEFT, 8'd0, 0);
		queue_item(FUNC_START, MODE_RIGHT, 8'd128, 315);
		queue_item(FUNC_SAMPLE, MODE_LEFT, 8'd0, 90);
		queue_item(FUNC_START, MODE_LEFT, 8'd1, 45);
		queue_item(FUNC_SAMPLE, MODE_LEFT, 8'd0, 361);
		wait_idle(4);

		// A zero quarter timeout ends the turn on its first tick.
		write_setting(0, 1, 10, 180, 359);
		queue_item(FUNC_START, MODE_LEFT, 8'd10, 90);
		queue_item(FUNC_TICK, MODE_LEFT, 8'd0, 0);
		queue_item(FUNC_START, MODE_HALF, 8'd50, 134);
		queue_item(FUNC_TICK, MODE_LEFT, 8'd0, 0);
		queue_item(FUNC_START, MODE_RIGHT, 8'd99, 256);
		queue_item(FUNC_SAMPLE, MODE_RIGHT, 8'd0, 5);
		wait_idle(4);

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: write_setting(8191, 8191, 15, 255, 511);
				1: write_setting(8000, 8000, 0, 0, 0);
				default: write_setting($urandom_range(20, 1), $urandom_range(30, 1),
					$urandom_range(10), $urandom_range(180), $urandom_range(359));
			endcase
			gap_pct = (phase == 2) ? 0 : 28;
			mark = queued;
			while (queued - mark < 90) queue_turn_sequence();
			wait_idle(4);
		end

		wait_idle(10);
		$display("Ran %0d requests under 8 register settings; %0d results checked.",
			accepted, checked);
		$display("Turns ended on target %0d times and by timeout %0d times.", reached_cnt,
			timeout_cnt);
		if (errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("Run did not finish in time.");
		$display("end of test: mismatches");
		$finish;
	end

endmodule
